// ===== rtl/core/irc_tok_pkg.sv =====
// Shared types, constants and match helpers for the IRC line tokenizer.
package irc_tok_pkg;

    // Highest parameter index (the counter saturates one above it) and command position limit.
    localparam int MAX_PARAM_INDEX    = 15;
    localparam int MAX_COMMAND_LENGTH = 15;

    localparam int NUM_CMDS      = 7;
    localparam int NUM_KEYS      = 3;
    localparam int KEY_POS_MAX   = 15;
    localparam int CMD_TEXT_BITS = 120;
    localparam int KEY_TEXT_BITS = 96;

    localparam int PCNT_W    = $clog2(MAX_PARAM_INDEX + 2);
    localparam int CMD_POS_W = $clog2(MAX_COMMAND_LENGTH + 1);
    localparam int KEY_POS_W = $clog2(KEY_POS_MAX + 1);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_START,
        PH_TAG_KEY,
        PH_TAG_VALUE,
        PH_AFTER_TAGS,
        PH_PREFIX_USER,
        PH_PREFIX_REST,
        PH_COMMAND,
        PH_PARAM_START,
        PH_MIDDLE,
        PH_TRAILING
    } t_phase;

    // Label given to each byte.
    typedef enum logic [2:0] {
        SEG_KEY,
        SEG_VALUE,
        SEG_USER,
        SEG_REST,
        SEG_CMD,
        SEG_MIDDLE,
        SEG_TRAIL,
        SEG_SEP
    } t_segment;

    typedef enum logic [2:0] {
        CMD_OTHER,
        CMD_CLEARMSG,
        CMD_GLOBALUSERSTATE,
        CMD_PRIVMSG,
        CMD_ROOMSTATE,
        CMD_USERNOTICE,
        CMD_USERSTATE,
        CMD_PING
    } t_cmd_code;

    typedef enum logic [1:0] {
        TAG_OTHER,
        TAG_USER_ID,
        TAG_DISPLAY_NAME,
        TAG_ID
    } t_tag_kind;

    // Delimiter characters.
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;

    // Known command and tag key names, right-aligned string literals.
    localparam logic [CMD_TEXT_BITS-1:0] CMD_TEXT [NUM_CMDS] = '{
        "CLEARMSG", "GLOBALUSERSTATE", "PRIVMSG", "ROOMSTATE",
        "USERNOTICE", "USERSTATE", "PING"
    };
    localparam int CMD_LEN [NUM_CMDS] = '{8, 15, 7, 9, 10, 9, 4};

    localparam logic [KEY_TEXT_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
        "user-id", "display-name", "id"
    };
    localparam int KEY_LEN [NUM_KEYS] = '{7, 12, 2};

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_phase                 phase;
        logic [PCNT_W-1:0]      param_count;
        logic [CMD_POS_W-1:0]   cmd_pos;
        logic [NUM_CMDS-1:0]    cmd_match;
        logic [KEY_POS_W-1:0]   key_pos;
        logic [NUM_KEYS-1:0]    key_match;
        logic [1:0]             first_len;
        logic                   bang;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:       PH_START,
        param_count: '0,
        cmd_pos:     '0,
        cmd_match:   '1,
        key_pos:     '0,
        key_match:   '1,
        first_len:   '0,
        bang:        1'b0
    };

    // Side-band labels of one result item, segment in the lowest bits.
    typedef struct packed {
        logic       privmsg_error;
        t_cmd_code  command_code;
        t_tag_kind  tag_kind;
        logic [3:0] param_index;
        t_segment   segment;
    } t_tok_user;

    // True when byte b equals character pos of command k.
    function automatic logic cmd_char_match(input int k, input logic [CMD_POS_W-1:0] pos,
                                            input logic [7:0] b);
        logic [CMD_TEXT_BITS-1:0] txt;
        int                       sh;
        txt = CMD_TEXT[k];
        if (int'(pos) >= CMD_LEN[k]) begin
            return 1'b0;
        end
        sh = (CMD_LEN[k] - 1 - int'(pos)) * 8;
        return txt[sh +: 8] == b;
    endfunction

    // True when byte b equals character pos of tag key k.
    function automatic logic key_char_match(input int k, input logic [KEY_POS_W-1:0] pos,
                                            input logic [7:0] b);
        logic [KEY_TEXT_BITS-1:0] txt;
        int                       sh;
        txt = KEY_TEXT[k];
        if (int'(pos) >= KEY_LEN[k]) begin
            return 1'b0;
        end
        sh = (KEY_LEN[k] - 1 - int'(pos)) * 8;
        return txt[sh +: 8] == b;
    endfunction

endpackage

// ===== rtl/core/irc_tok_step.sv =====
// Combinational parse step: labels one byte and computes the next parser state.
module irc_tok_step import irc_tok_pkg::*; (
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_parse_state o_next_state,
    output t_tok_user    o_user
);

    logic [NUM_CMDS-1:0]  cmd_match_upd;
    logic [CMD_POS_W-1:0] cmd_pos_upd;
    logic [NUM_KEYS-1:0]  key_match_upd;
    logic [KEY_POS_W-1:0] key_pos_upd;
    logic [NUM_KEYS-1:0]  key_match_fin;

    // Candidate updates of the command and key matchers for this byte.
    always_comb begin
        for (int k = 0; k < NUM_CMDS; k++) begin
            cmd_match_upd[k] = i_state.cmd_match[k] & cmd_char_match(k, i_state.cmd_pos, i_byte);
        end
        cmd_pos_upd = (int'(i_state.cmd_pos) < MAX_COMMAND_LENGTH) ?
                      i_state.cmd_pos + 1'b1 : i_state.cmd_pos;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_match_upd[k] = i_state.key_match[k] & key_char_match(k, i_state.key_pos, i_byte);
            key_match_fin[k] = i_state.key_match[k] & (KEY_LEN[k] == int'(i_state.key_pos));
        end
        key_pos_upd = (int'(i_state.key_pos) < KEY_POS_MAX) ?
                      i_state.key_pos + 1'b1 : i_state.key_pos;
    end

    t_parse_state nxt;
    t_segment     seg;
    t_tag_kind    kind;
    t_cmd_code    code;
    logic         in_param;
    logic         take_cmd;
    logic         note_param;
    logic [3:0]   pidx;
    logic         err;

    // Phase transitions, byte label and end-of-line results.
    always_comb begin
        nxt        = i_state;
        seg        = SEG_SEP;
        kind       = TAG_OTHER;
        in_param   = 1'b0;
        take_cmd   = 1'b0;
        note_param = 1'b0;
        code       = CMD_OTHER;
        err        = 1'b0;
        pidx       = '0;

        case (i_state.phase)
            PH_START: begin
                if (i_byte == CH_AT) begin
                    nxt.phase     = PH_TAG_KEY;
                    nxt.key_pos   = '0;
                    nxt.key_match = '1;
                end else if (i_byte == CH_COLON) begin
                    nxt.phase = PH_PREFIX_USER;
                end else begin
                    take_cmd = 1'b1;
                end
            end
            PH_TAG_KEY: begin
                if (i_byte == CH_SEMI) begin
                    nxt.key_pos   = '0;
                    nxt.key_match = '1;
                end else if (i_byte == CH_EQ) begin
                    nxt.key_match = key_match_fin;
                    nxt.phase     = PH_TAG_VALUE;
                end else if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_AFTER_TAGS;
                end else begin
                    seg           = SEG_KEY;
                    nxt.key_match = key_match_upd;
                    nxt.key_pos   = key_pos_upd;
                end
            end
            PH_TAG_VALUE: begin
                if (i_byte == CH_SEMI) begin
                    nxt.key_pos   = '0;
                    nxt.key_match = '1;
                    nxt.phase     = PH_TAG_KEY;
                end else if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_AFTER_TAGS;
                end else begin
                    seg = SEG_VALUE;
                    if (i_state.key_match[0]) begin
                        kind = TAG_USER_ID;
                    end else if (i_state.key_match[1]) begin
                        kind = TAG_DISPLAY_NAME;
                    end else if (i_state.key_match[2]) begin
                        kind = TAG_ID;
                    end
                end
            end
            PH_AFTER_TAGS: begin
                if (i_byte == CH_COLON) begin
                    nxt.phase = PH_PREFIX_USER;
                end else begin
                    take_cmd = 1'b1;
                end
            end
            PH_PREFIX_USER: begin
                if (i_byte == CH_BANG) begin
                    nxt.bang  = 1'b1;
                    nxt.phase = PH_PREFIX_REST;
                end else if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_COMMAND;
                end else begin
                    seg = SEG_USER;
                end
            end
            PH_PREFIX_REST: begin
                if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_COMMAND;
                end else begin
                    seg = SEG_REST;
                end
            end
            PH_COMMAND: begin
                take_cmd = 1'b1;
            end
            PH_PARAM_START: begin
                if (i_state.param_count < PCNT_W'(MAX_PARAM_INDEX + 1)) begin
                    nxt.param_count = i_state.param_count + 1'b1;
                end
                in_param = 1'b1;
                if (i_byte == CH_COLON) begin
                    nxt.phase = PH_TRAILING;
                end else if (i_byte != CH_SPACE) begin
                    seg        = SEG_MIDDLE;
                    note_param = 1'b1;
                    nxt.phase  = PH_MIDDLE;
                end
            end
            PH_MIDDLE: begin
                in_param = 1'b1;
                if (i_byte == CH_SPACE) begin
                    nxt.phase = PH_PARAM_START;
                end else begin
                    seg        = SEG_MIDDLE;
                    note_param = 1'b1;
                end
            end
            PH_TRAILING: begin
                in_param   = 1'b1;
                seg        = SEG_TRAIL;
                note_param = 1'b1;
            end
            default: begin
                nxt.phase = PH_START;
                take_cmd  = 1'b1;
            end
        endcase

        // Command byte, or the space that ends the command.
        if (take_cmd) begin
            if (i_byte == CH_SPACE) begin
                nxt.phase = PH_PARAM_START;
                seg       = SEG_SEP;
            end else begin
                nxt.cmd_match = cmd_match_upd;
                nxt.cmd_pos   = cmd_pos_upd;
                nxt.phase     = PH_COMMAND;
                seg           = SEG_CMD;
            end
        end

        // Length of the first parameter, saturating at two.
        if (note_param && nxt.param_count == PCNT_W'(1) && nxt.first_len < 2'd2) begin
            nxt.first_len = nxt.first_len + 1'b1;
        end

        if (in_param && nxt.param_count != '0) begin
            pidx = 4'(nxt.param_count - 1'b1);
        end

        // Command code and error check on the final byte of the line.
        if (i_last) begin
            for (int k = NUM_CMDS - 1; k >= 0; k--) begin
                if (nxt.cmd_match[k] && CMD_LEN[k] == int'(nxt.cmd_pos)) begin
                    code = t_cmd_code'(3'(k + 1));
                end
            end
            if (code == CMD_PRIVMSG &&
                (nxt.param_count < PCNT_W'(2) || nxt.first_len < 2'd2 || !nxt.bang)) begin
                err = 1'b1;
            end
            nxt = PARSE_RESET;
        end
    end

    assign o_next_state         = nxt;
    assign o_user.segment       = seg;
    assign o_user.param_index   = pidx;
    assign o_user.tag_kind      = kind;
    assign o_user.command_code  = code;
    assign o_user.privmsg_error = err;

endmodule

// ===== rtl/core/irc_line_tokenizer_core.sv =====
// Top level of the IRC line tokenizer: input register, parse step, result register.
//
//  Channel  | Direction | Payload                                           | End marker
//  s_axis   | in        | tdata[7:0] data_byte                              | tlast line_end
//  m_axis   | out       | tdata[7:0] byte_out; tuser labels (see port list) | tlast is_last
//
// One item per cycle unless m_axis stalls; a byte passes the input, then the result register.
// The parse step runs between the input register and the result register, once per item.
// Reset is synchronous and active low; it returns the parser to line start.
// A stall on m_axis holds the result register and backs up into s_axis_tready.
module irc_line_tokenizer_core import irc_tok_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
    output logic [12:0] m_axis_tuser,   // [2:0] segment, [6:3] param_index,
                                        // [8:7] tag_kind, [11:9] command_code,
                                        // [12] privmsg_error
    output logic        m_axis_tlast    // is_last
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_last;
    t_tok_user    r_out_user;
    t_parse_state r_state;

    t_parse_state n_state;
    t_tok_user    n_user;
    logic         out_free;
    logic         advance;

    // Move an item into the result register when that register is free or draining.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    irc_tok_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_next_state (n_state),
        .o_user       (n_user)
    );

    // Control and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PARSE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out_last <= r_in_last;
            r_out_user <= n_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/irc_tok_checker.sv =====
// Port-level checks of the IRC line tokenizer and their binding to the top level.
module irc_tok_checker import irc_tok_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [12:0] m_axis_tuser,
    input logic        m_axis_tlast
);

    t_tok_user usr;
    assign usr = m_axis_tuser;

    // A stalled result item holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // Command code and error flag appear only on the final byte of a line.
    a_code_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            usr.command_code == CMD_OTHER && !usr.privmsg_error)
        else $error("command result outside the final byte");

    // The error flag only accompanies a PRIVMSG command.
    a_err_privmsg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && usr.privmsg_error |-> usr.command_code == CMD_PRIVMSG)
        else $error("error flag without PRIVMSG");

    // Tag kind is reported on tag value bytes only.
    a_kind_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && usr.tag_kind != TAG_OTHER |-> usr.segment == SEG_VALUE)
        else $error("tag kind outside a tag value");

    // A nonzero parameter index belongs to parameter bytes or their separators.
    a_pidx_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && usr.param_index != 4'd0 |->
            usr.segment == SEG_MIDDLE || usr.segment == SEG_TRAIL
            || usr.segment == SEG_SEP)
        else $error("parameter index outside the parameters");

endmodule

bind irc_line_tokenizer_core irc_tok_checker u_irc_tok_checker (.*);

// ===== test/irc_line_tokenizer_core_tb.sv =====
// Self-checking testbench for the IRC line tokenizer core: random lines, random stalls.
module irc_line_tokenizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irc_tok_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One byte queued for the input stream; a drain entry makes the sender wait.
    typedef struct {
        logic [7:0] octet;
        logic       line_end;
        logic       drain;
    } feed_item_t;

    // Labels expected for one byte.
    typedef struct {
        logic [7:0] octet;
        t_segment   segment;
        logic [3:0] param_index;
        t_tag_kind  tag_kind;
        logic       is_last;
        t_cmd_code  command_code;
        logic       privmsg_error;
    } tok_label_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] byte_out
    logic [12:0] m_axis_tuser;           // [2:0] segment, [6:3] param_index, [8:7] tag_kind,
                                         // [11:9] command_code, [12] privmsg_error
    logic        m_axis_tlast;           // is_last

    feed_item_t  pending_octets[$];
    tok_label_t  expected_labels[$];
    logic [7:0]  line_buf[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Known names, in command code order, and the text choices for random lines.
    string cmd_names [7] = '{"CLEARMSG", "GLOBALUSERSTATE", "PRIVMSG", "ROOMSTATE",
                             "USERNOTICE", "USERSTATE", "PING"};
    string key_names [3] = '{"user-id", "display-name", "id"};
    string cmd_choices [16] = '{"CLEARMSG", "GLOBALUSERSTATE", "PRIVMSG", "ROOMSTATE",
                                "USERNOTICE", "USERSTATE", "PING", "PRIVMSG", "PRIVMSG",
                                "PRIVMS", "PRIVMSGX", "PIN", "GLOBALUSERSTATEX", "privmsg",
                                "001", ""};
    string key_choices [9] = '{"user-id", "display-name", "id", "i", "idx", "user-i",
                               "display-namex", "", "ab"};

    // Parser state of the prediction.
    t_phase     tk_phase;
    logic [4:0] tk_param_count;
    logic [3:0] tk_cmd_pos;
    logic [6:0] tk_cmd_match;
    logic [3:0] tk_key_pos;
    logic [2:0] tk_key_match;
    logic [1:0] tk_first_len;
    logic       tk_bang;

    irc_line_tokenizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Return the parser to line start.
    function automatic void tokenizer_restart();
        tk_phase       = PH_START;
        tk_param_count = '0;
        tk_cmd_pos     = '0;
        tk_cmd_match   = '1;
        tk_key_pos     = '0;
        tk_key_match   = '1;
        tk_first_len   = '0;
        tk_bang        = 1'b0;
    endfunction

    // A byte where the command may go: a space ends it, anything else extends it.
    function automatic t_segment command_octet(logic [7:0] octet);
        if (octet == CH_SPACE) begin
            tk_phase = PH_PARAM_START;
            return SEG_SEP;
        end
        for (int k = 0; k < 7; k++) begin
            if (tk_cmd_match[k] && (int'(tk_cmd_pos) >= cmd_names[k].len() ||
                                    cmd_names[k][int'(tk_cmd_pos)] != octet)) begin
                tk_cmd_match[k] = 1'b0;
            end
        end
        if (tk_cmd_pos < MAX_COMMAND_LENGTH) begin
            tk_cmd_pos++;
        end
        tk_phase = PH_COMMAND;
        return SEG_CMD;
    endfunction

    // Only the first parameter's length matters, and only up to two.
    function automatic void note_param_content();
        if (tk_param_count == 1 && tk_first_len < 2) begin
            tk_first_len++;
        end
    endfunction

    // Label one accepted byte and advance the parser.
    function automatic tok_label_t tokenize_octet(logic [7:0] octet, logic line_end);
        tok_label_t lbl;
        logic       in_param;
        lbl.octet         = octet;
        lbl.segment       = SEG_SEP;
        lbl.param_index   = '0;
        lbl.tag_kind      = TAG_OTHER;
        lbl.is_last       = line_end;
        lbl.command_code  = CMD_OTHER;
        lbl.privmsg_error = 1'b0;
        in_param = 1'b0;
        case (tk_phase)
            PH_START: begin
                if (octet == CH_AT) begin
                    tk_phase     = PH_TAG_KEY;
                    tk_key_pos   = '0;
                    tk_key_match = '1;
                end else if (octet == CH_COLON) begin
                    tk_phase = PH_PREFIX_USER;
                end else begin
                    lbl.segment = command_octet(octet);
                end
            end
            PH_TAG_KEY: begin
                if (octet == CH_SEMI) begin
                    tk_key_pos   = '0;
                    tk_key_match = '1;
                end else if (octet == CH_EQ) begin
                    // A key matches only if it ended at exactly the name's length.
                    for (int k = 0; k < 3; k++) begin
                        if (key_names[k].len() != int'(tk_key_pos)) begin
                            tk_key_match[k] = 1'b0;
                        end
                    end
                    tk_phase = PH_TAG_VALUE;
                end else if (octet == CH_SPACE) begin
                    tk_phase = PH_AFTER_TAGS;
                end else begin
                    lbl.segment = SEG_KEY;
                    for (int k = 0; k < 3; k++) begin
                        if (tk_key_match[k] && (int'(tk_key_pos) >= key_names[k].len() ||
                                                key_names[k][int'(tk_key_pos)] != octet)) begin
                            tk_key_match[k] = 1'b0;
                        end
                    end
                    if (tk_key_pos < 15) begin
                        tk_key_pos++;
                    end
                end
            end
            PH_TAG_VALUE: begin
                if (octet == CH_SEMI) begin
                    tk_key_pos   = '0;
                    tk_key_match = '1;
                    tk_phase     = PH_TAG_KEY;
                end else if (octet == CH_SPACE) begin
                    tk_phase = PH_AFTER_TAGS;
                end else begin
                    lbl.segment = SEG_VALUE;
                    if (tk_key_match[0]) begin
                        lbl.tag_kind = TAG_USER_ID;
                    end else if (tk_key_match[1]) begin
                        lbl.tag_kind = TAG_DISPLAY_NAME;
                    end else if (tk_key_match[2]) begin
                        lbl.tag_kind = TAG_ID;
                    end
                end
            end
            PH_AFTER_TAGS: begin
                if (octet == CH_COLON) begin
                    tk_phase = PH_PREFIX_USER;
                end else begin
                    lbl.segment = command_octet(octet);
                end
            end
            PH_PREFIX_USER: begin
                if (octet == CH_BANG) begin
                    tk_bang  = 1'b1;
                    tk_phase = PH_PREFIX_REST;
                end else if (octet == CH_SPACE) begin
                    tk_phase = PH_COMMAND;
                end else begin
                    lbl.segment = SEG_USER;
                end
            end
            PH_PREFIX_REST: begin
                if (octet == CH_SPACE) begin
                    tk_phase = PH_COMMAND;
                end else begin
                    lbl.segment = SEG_REST;
                end
            end
            PH_COMMAND: begin
                lbl.segment = command_octet(octet);
            end
            PH_PARAM_START: begin
                if (tk_param_count < MAX_PARAM_INDEX + 1) begin
                    tk_param_count++;
                end
                in_param = 1'b1;
                if (octet == CH_COLON) begin
                    tk_phase = PH_TRAILING;
                end else if (octet != CH_SPACE) begin
                    lbl.segment = SEG_MIDDLE;
                    note_param_content();
                    tk_phase = PH_MIDDLE;
                end
            end
            PH_MIDDLE: begin
                in_param = 1'b1;
                if (octet == CH_SPACE) begin
                    tk_phase = PH_PARAM_START;
                end else begin
                    lbl.segment = SEG_MIDDLE;
                    note_param_content();
                end
            end
            PH_TRAILING: begin
                in_param = 1'b1;
                lbl.segment = SEG_TRAIL;
                note_param_content();
            end
            default: begin
                tk_phase = PH_START;
                lbl.segment = command_octet(octet);
            end
        endcase

        if (in_param && tk_param_count > 0) begin
            lbl.param_index = 4'(tk_param_count - 1);
        end

        // Command code and PRIVMSG check are reported on the final byte only.
        if (line_end) begin
            for (int k = 6; k >= 0; k--) begin
                if (tk_cmd_match[k] && cmd_names[k].len() == int'(tk_cmd_pos)) begin
                    lbl.command_code = t_cmd_code'(3'(k + 1));
                end
            end
            if (lbl.command_code == CMD_PRIVMSG &&
                (tk_param_count < 2 || tk_first_len < 2 || !tk_bang)) begin
                lbl.privmsg_error = 1'b1;
            end
            tokenizer_restart();
        end
        return lbl;
    endfunction

    // Line building helpers, all appending to line_buf.
    function automatic void add_octet(logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void add_string(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_octet(s[i]);
        end
    endfunction

    function automatic void add_word(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                add_octet(8'($urandom_range(0, 255)));
            end else begin
                add_octet(8'($urandom_range(8'h61, 8'h7a)));
            end
        end
    endfunction

    function automatic void add_tags();
        int unsigned n_tags;
        n_tags = $urandom_range(1, 3);
        add_octet(CH_AT);
        for (int unsigned t = 0; t < n_tags; t++) begin
            if (t > 0) begin
                add_octet(CH_SEMI);
                if ($urandom_range(0, 7) == 0) begin
                    add_octet(CH_SEMI);
                end
            end
            add_string(key_choices[$urandom_range(0, 8)]);
            if ($urandom_range(0, 4) != 0) begin
                add_octet(CH_EQ);
                add_word($urandom_range(0, 4));
                if ($urandom_range(0, 7) == 0) begin
                    add_octet(CH_EQ);
                    add_word(1);
                end
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            add_octet(CH_SPACE);
        end
    endfunction

    function automatic void add_prefix();
        add_octet(CH_COLON);
        add_word($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) begin
            add_octet(CH_BANG);
            add_word($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) begin
                add_octet(CH_AT);
                add_word($urandom_range(1, 3));
            end
            if ($urandom_range(0, 7) == 0) begin
                add_octet(CH_BANG);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            add_octet(CH_SPACE);
        end
    endfunction

    function automatic void add_command();
        int unsigned n;
        if ($urandom_range(0, 9) == 0) begin
            // Longer than any known command, so the position saturates.
            n = $urandom_range(16, 20);
            for (int unsigned i = 0; i < n; i++) begin
                add_octet(8'($urandom_range(8'h41, 8'h5a)));
            end
        end else begin
            add_string(cmd_choices[$urandom_range(0, 15)]);
        end
    endfunction

    function automatic void add_params();
        int unsigned n_params;
        n_params = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 4);
        for (int unsigned p = 0; p < n_params; p++) begin
            add_octet(CH_SPACE);
            if ($urandom_range(0, 7) == 0) begin
                add_octet(CH_SPACE);
            end
            if (p == n_params - 1 && $urandom_range(0, 1) == 1) begin
                add_octet(CH_COLON);
                add_word($urandom_range(0, 4));
                if ($urandom_range(0, 1) == 1) begin
                    add_octet(CH_SPACE);
                    add_word($urandom_range(0, 4));
                end
            end else begin
                add_word((p == 0) ? $urandom_range(0, 3) : $urandom_range(1, 4));
            end
        end
    endfunction

    // Move line_buf into the send queue, marking its final byte.
    function automatic void flush_line();
        feed_item_t it;
        for (int i = 0; i < line_buf.size(); i++) begin
            it.octet    = line_buf[i];
            it.line_end = (i == line_buf.size() - 1);
            it.drain    = 1'b0;
            pending_octets = {pending_octets, it};
        end
        line_buf.delete();
    endfunction

    function automatic void queue_drain();
        feed_item_t it;
        it.octet    = 8'h00;
        it.line_end = 1'b0;
        it.drain    = 1'b1;
        pending_octets = {pending_octets, it};
    endfunction

    // Mostly well-formed lines with random content; some noise and cut-off lines.
    function automatic void random_line();
        int unsigned n;
        int unsigned cut;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 10);
            for (int unsigned i = 0; i < n; i++) begin
                add_octet(8'($urandom_range(0, 255)));
            end
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                add_tags();
            end
            if ($urandom_range(0, 1) == 0) begin
                add_prefix();
            end
            add_command();
            add_params();
            if ($urandom_range(0, 7) == 0 && line_buf.size() > 1) begin
                cut = $urandom_range(1, line_buf.size() - 1);
                while (line_buf.size() > cut) begin
                    void'(line_buf.pop_back());
                end
            end
        end
        if (line_buf.size() == 0) begin
            add_octet(8'($urandom_range(0, 255)));
        end
        flush_line();
    endfunction

    // Sender: bursts of random length with random gaps; predicts each accepted byte.
    always @(posedge i_clk) begin
        feed_item_t  nxt;
        tok_label_t  lbl;
        logic        offer;
        static int unsigned burst_left = 0;
        static int unsigned gap_left = 0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                lbl = tokenize_octet(s_axis_tdata, s_axis_tlast);
                expected_labels = {expected_labels, lbl};
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                offer = 1'b0;
                if (pending_octets.size() > 0 && pending_octets[0].drain) begin
                    // Hold off until every outstanding result has come back.
                    if (expected_labels.size() == 0) begin
                        void'(pending_octets.pop_front());
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_octets.size() > 0) begin
                    nxt = pending_octets.pop_front();
                    s_axis_tdata <= nxt.octet;
                    s_axis_tlast <= nxt.line_end;
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = 1;
                            2: gap_left = $urandom_range(2, 6);
                            default: gap_left = $urandom_range(0, 1);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // Receiver: switches among random stall patterns; one long hold-off.
    always @(posedge i_clk) begin
        static int unsigned taken = 0;
        static int unsigned mode = 0;
        static int unsigned mode_left = 0;
        static int unsigned hold_left = 0;
        static logic        hold_done = 1'b0;
        static logic [1:0]  beat = '0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                taken++;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 80);
            end else begin
                mode_left--;
            end
            beat++;
            if (!hold_done && taken >= 150) begin
                hold_done = 1'b1;
                hold_left = 90;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 2) != 0);
                    default: m_axis_tready <= (beat == 2'd0);
                endcase
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result item with the oldest expected label set.
    always @(posedge i_clk) begin
        tok_label_t want;
        t_tok_user  got_user;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_labels.size() == 0) begin
                $error("unexpected result item: byte_out %0d", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_labels.pop_front();
                got_user = m_axis_tuser;
                check_field("byte_out", want.octet, m_axis_tdata);
                check_field("segment", want.segment, got_user.segment);
                check_field("param_index", want.param_index, got_user.param_index);
                check_field("tag_kind", want.tag_kind, got_user.tag_kind);
                check_field("is_last", want.is_last, m_axis_tlast);
                check_field("command_code", want.command_code, got_user.command_code);
                check_field("privmsg_error", want.privmsg_error, got_user.privmsg_error);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[irc_line_tokenizer_core] ERROR");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned random_target;
        logic        mid_drain_done;
        tokenizer_restart();

        // Tags, prefix with user split, PRIVMSG, middle and trailing parameters.
        add_string("@id=7 :n!u PRIVMSG #c :x");
        flush_line();
        // Single-byte lines at both ends of the byte range.
        add_octet(8'h00);
        flush_line();
        add_octet(8'hFF);
        flush_line();
        queue_drain();

        random_target = pending_octets.size() + 650;
        mid_drain_done = 1'b0;
        while (pending_octets.size() < random_target) begin
            random_line();
            if (!mid_drain_done && pending_octets.size() > random_target - 300) begin
                queue_drain();
                mid_drain_done = 1'b1;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_octets.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (expected_labels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[irc_line_tokenizer_core] OK");
        end else begin
            $display("[irc_line_tokenizer_core] ERROR");
        end
        $finish;
    end

endmodule
